// File: hw/rtl/btpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btpc_pkg;

  // Channel payloads
  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic [31:0]        press_q8;
    logic               press_held;
  } out_item_t;

  // Serial multiplier request and status
  typedef struct packed {
    logic        start;
    logic [6:0]  nbits;
    logic [63:0] mcand;
    logic [63:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  // Serial divider request and status
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEMP_TRIM    = 2'd0;
  localparam logic [1:0] CFG_PRESS_TRIM_A = 2'd1;
  localparam logic [1:0] CFG_PRESS_TRIM_B = 2'd2;
  localparam logic [1:0] CFG_PRESS_TRIM_C = 2'd3;

  // Multiplier widths (two's complement multiplier bits)
  localparam logic [6:0] NB_TRIM  = 7'd16;
  localparam logic [6:0] NB_UTRIM = 7'd17;
  localparam logic [6:0] NB_DIFF  = 7'd17;
  localparam logic [6:0] NB_FINE  = 7'd26;
  localparam logic [6:0] NB_SCALE = 7'd13;
  localparam logic [6:0] NB_FULL  = 7'd64;
  localparam logic [6:0] DIV_STEPS = 7'd64;

  // Scheme constants
  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_BASE  = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [63:0] TEMP_ROUND  = 64'd128;
  localparam logic [63:0] ONE_Q47     = 64'h0000_8000_0000_0000;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] ux16(input logic [15:0] v);
    ux16 = {48'd0, v};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/btpc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module btpc_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire btpc_pkg::mul_req_t req,
  output btpc_pkg::mul_rsp_t      rsp
);
  import btpc_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [63:0] acc_r;
  logic [63:0] mc_r;
  logic [63:0] mp_r;

  // Shift-add, one multiplier bit per cycle; the top bit carries negative weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
        acc_r  <= 64'd0;
        mc_r   <= req.mcand;
        mp_r   <= req.mplier;
      end else if (busy_r) begin
        if (mp_r[0]) begin
          acc_r <= (cnt_r == 7'd1) ? acc_r - mc_r : acc_r + mc_r;
        end
        mc_r  <= {mc_r[62:0], 1'b0};
        mp_r  <= {1'b0, mp_r[63:1]};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

`default_nettype wire

// File: hw/rtl/btpc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module btpc_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire btpc_pkg::div_req_t req,
  output btpc_pkg::div_rsp_t      rsp
);
  import btpc_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] quot_r;
  logic [63:0] dvs_r;
  logic [64:0] shifted;
  logic [64:0] diff;

  // Trial subtract of the divisor from the shifted remainder
  assign shifted = {rem_r, quot_r[63]};
  assign diff    = shifted - {1'b0, dvs_r};

  // Restoring divide on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_STEPS;
        neg_r  <= req.dividend[63] ^ req.divisor[63];
        rem_r  <= 64'd0;
        quot_r <= req.dividend[63] ? 64'd0 - req.dividend : req.dividend;
        dvs_r  <= req.divisor[63] ? 64'd0 - req.divisor : req.divisor;
      end else if (busy_r) begin
        rem_r  <= diff[64] ? shifted[63:0] : diff[63:0];
        quot_r <= {quot_r[62:0], ~diff[64]};
        cnt_r  <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Apply the sign, truncating toward zero
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? 64'd0 - quot_r : quot_r;

endmodule

`default_nettype wire

// File: hw/rtl/baro_temp_pressure_compensation_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   in_item_t  (raw_temp, raw_press)
// out_      output     out_valid/out_stall out_item_t (temp_centi, press_q8, press_held)
// cfg_      input      cfg_we              cfg_index, cfg_wdata (48 bits)
//
// One item at a time, computed with thirteen bit-serial multiplies on one shared
// shift-add unit and a 64-step restoring divide; the divide and the last four
// multiplies are skipped when the divisor is zero.
// Reset (rst_n low, synchronous) clears the sequencer, the trims and the last pressure.
// A finished result waits in the output register; the next item is taken
// meanwhile and only its completion waits on out_stall.
module baro_temp_pressure_compensation_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire btpc_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output btpc_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [47:0]          cfg_wdata
);
  import btpc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_TA, S_TD, S_TB, S_TC, S_PSQ, S_PB6, S_PB5, S_PA3, S_PA2,
    S_PA1, S_PNUM, S_DIV, S_PSS, S_P9, S_P8, S_PFIN, S_DONE
  } state_t;

  state_t      state_r;
  logic        mul_go_r;
  logic        div_go_r;
  logic [47:0] temp_trim_r;
  logic [47:0] press_trim_a_r;
  logic [47:0] press_trim_b_r;
  logic [47:0] press_trim_c_r;
  logic [31:0] last_r;
  logic [19:0] rt_r;
  logic [19:0] rp_r;
  logic [63:0] ta_r;
  logic [63:0] dd_r;
  logic [63:0] fine_r;
  logic [63:0] a0_r;
  logic [63:0] sq_r;
  logic [63:0] pa_r;
  logic [63:0] pb_r;
  logic [63:0] q_r;
  logic signed [15:0] temp_res_r;
  logic [31:0] press_res_r;
  logic        held_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  mul_req_t    mreq;
  mul_rsp_t    mrsp;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] x1, dt, tsum, tval, psum, pval, pa_new, pnum_base;
  logic signed [63:0] tval_s, pval_s;

  // Unpack the trims
  assign t1 = ux16(temp_trim_r[15:0]);
  assign t2 = sx16(temp_trim_r[31:16]);
  assign t3 = sx16(temp_trim_r[47:32]);
  assign p1 = ux16(press_trim_a_r[15:0]);
  assign p2 = sx16(press_trim_a_r[31:16]);
  assign p3 = sx16(press_trim_a_r[47:32]);
  assign p4 = sx16(press_trim_b_r[15:0]);
  assign p5 = sx16(press_trim_b_r[31:16]);
  assign p6 = sx16(press_trim_b_r[47:32]);
  assign p7 = sx16(press_trim_c_r[15:0]);
  assign p8 = sx16(press_trim_c_r[31:16]);
  assign p9 = sx16(press_trim_c_r[47:32]);

  // Temperature differences
  assign x1 = {47'd0, rt_r[19:3]} - {t1[62:0], 1'b0};
  assign dt = {48'd0, rt_r[19:4]} - t1;

  // Temperature scaling: (fine * 5 + 128) >>> 8
  assign tsum   = {fine_r[61:0], 2'b00} + fine_r + TEMP_ROUND;
  assign tval_s = $signed(tsum) >>> 8;
  assign tval   = tval_s;

  // Final pressure sum
  assign psum   = q_r + pa_r + pb_r;
  assign pval_s = ($signed(psum) >>> 8) + $signed({p7[59:0], 4'd0});
  assign pval   = pval_s;

  // Divisor after the P1 scaling
  assign pa_new = $signed(mrsp.prod) >>> 33;

  // Pressure numerator base before the shift
  assign pnum_base = PRESS_BASE - {44'd0, rp_r};

  // Select multiplier operands for the current step
  always_comb begin
    mreq.start  = mul_go_r;
    mreq.nbits  = NB_TRIM;
    mreq.mcand  = sq_r;
    mreq.mplier = p6;
    case (state_r)
      S_TA: begin
        mreq.mcand  = x1;
        mreq.mplier = t2;
      end
      S_TD: begin
        mreq.nbits  = NB_DIFF;
        mreq.mcand  = dt;
        mreq.mplier = dt;
      end
      S_TB: begin
        mreq.mcand  = dd_r;
        mreq.mplier = t3;
      end
      S_PSQ: begin
        mreq.nbits  = NB_FINE;
        mreq.mcand  = a0_r;
        mreq.mplier = a0_r;
      end
      S_PB5: begin
        mreq.mcand  = a0_r;
        mreq.mplier = p5;
      end
      S_PA3: begin
        mreq.mplier = p3;
      end
      S_PA2: begin
        mreq.mcand  = a0_r;
        mreq.mplier = p2;
      end
      S_PA1: begin
        mreq.nbits  = NB_UTRIM;
        mreq.mcand  = ONE_Q47 + pa_r;
        mreq.mplier = p1;
      end
      S_PNUM: begin
        mreq.nbits  = NB_SCALE;
        mreq.mcand  = {pnum_base[32:0], 31'd0} - pb_r;
        mreq.mplier = PRESS_SCALE;
      end
      S_PSS: begin
        mreq.nbits  = NB_FULL;
        mreq.mcand  = $signed(q_r) >>> 13;
        mreq.mplier = $signed(q_r) >>> 13;
      end
      S_P9: begin
        mreq.mplier = p9;
      end
      S_P8: begin
        mreq.mcand  = q_r;
        mreq.mplier = p8;
      end
      default: begin
        mreq.mcand  = sq_r;
      end
    endcase
  end

  assign dreq.start    = div_go_r;
  assign dreq.dividend = pb_r;
  assign dreq.divisor  = pa_r;

  btpc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  btpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r    <= 48'd0;
      press_trim_a_r <= 48'd0;
      press_trim_b_r <= 48'd0;
      press_trim_c_r <= 48'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_TRIM:    temp_trim_r    <= cfg_wdata;
        CFG_PRESS_TRIM_A: press_trim_a_r <= cfg_wdata;
        CFG_PRESS_TRIM_B: press_trim_b_r <= cfg_wdata;
        CFG_PRESS_TRIM_C: press_trim_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequence the compensation steps and hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= 32'd0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            rt_r     <= in_data.raw_temp;
            rp_r     <= in_data.raw_press;
            state_r  <= S_TA;
            mul_go_r <= 1'b1;
          end
        end
        S_TA: begin
          if (mrsp.done) begin
            ta_r     <= $signed(mrsp.prod) >>> 11;
            state_r  <= S_TD;
            mul_go_r <= 1'b1;
          end
        end
        S_TD: begin
          if (mrsp.done) begin
            dd_r     <= $signed(mrsp.prod) >>> 12;
            state_r  <= S_TB;
            mul_go_r <= 1'b1;
          end
        end
        S_TB: begin
          if (mrsp.done) begin
            fine_r  <= ta_r + 64'($signed(mrsp.prod) >>> 14);
            state_r <= S_TC;
          end
        end
        S_TC: begin
          // Saturate temperature to 16 bits signed
          if (tval_s > 64'sd32767) begin
            temp_res_r <= 16'sh7FFF;
          end else if (tval_s < -64'sd32768) begin
            temp_res_r <= 16'sh8000;
          end else begin
            temp_res_r <= tval[15:0];
          end
          a0_r     <= fine_r - FINE_OFFSET;
          state_r  <= S_PSQ;
          mul_go_r <= 1'b1;
        end
        S_PSQ: begin
          if (mrsp.done) begin
            sq_r     <= mrsp.prod;
            state_r  <= S_PB6;
            mul_go_r <= 1'b1;
          end
        end
        S_PB6: begin
          if (mrsp.done) begin
            pb_r     <= mrsp.prod + {p4[28:0], 35'd0};
            state_r  <= S_PB5;
            mul_go_r <= 1'b1;
          end
        end
        S_PB5: begin
          if (mrsp.done) begin
            pb_r     <= pb_r + {mrsp.prod[46:0], 17'd0};
            state_r  <= S_PA3;
            mul_go_r <= 1'b1;
          end
        end
        S_PA3: begin
          if (mrsp.done) begin
            pa_r     <= $signed(mrsp.prod) >>> 8;
            state_r  <= S_PA2;
            mul_go_r <= 1'b1;
          end
        end
        S_PA2: begin
          if (mrsp.done) begin
            pa_r     <= pa_r + {mrsp.prod[51:0], 12'd0};
            state_r  <= S_PA1;
            mul_go_r <= 1'b1;
          end
        end
        S_PA1: begin
          if (mrsp.done) begin
            pa_r <= pa_new;
            if (pa_new == 64'd0) begin
              // Zero divisor: repeat the last pressure
              press_res_r <= last_r;
              held_r      <= 1'b1;
              state_r     <= S_DONE;
            end else begin
              state_r  <= S_PNUM;
              mul_go_r <= 1'b1;
            end
          end
        end
        S_PNUM: begin
          if (mrsp.done) begin
            pb_r     <= mrsp.prod;
            state_r  <= S_DIV;
            div_go_r <= 1'b1;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            q_r      <= drsp.quot;
            state_r  <= S_PSS;
            mul_go_r <= 1'b1;
          end
        end
        S_PSS: begin
          if (mrsp.done) begin
            sq_r     <= mrsp.prod;
            state_r  <= S_P9;
            mul_go_r <= 1'b1;
          end
        end
        S_P9: begin
          if (mrsp.done) begin
            pa_r     <= $signed(mrsp.prod) >>> 25;
            state_r  <= S_P8;
            mul_go_r <= 1'b1;
          end
        end
        S_P8: begin
          if (mrsp.done) begin
            pb_r    <= $signed(mrsp.prod) >>> 19;
            state_r <= S_PFIN;
          end
        end
        S_PFIN: begin
          // Clamp pressure to the unsigned 32-bit range
          if (pval[63]) begin
            press_res_r <= 32'd0;
            last_r      <= 32'd0;
          end else if (pval[63:32] != 32'd0) begin
            press_res_r <= 32'hFFFF_FFFF;
            last_r      <= 32'hFFFF_FFFF;
          end else begin
            press_res_r <= pval[31:0];
            last_r      <= pval[31:0];
          end
          held_r  <= 1'b0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.temp_centi <= temp_res_r;
            out_data_r.press_q8   <= press_res_r;
            out_data_r.press_held <= held_r;
            out_valid_r           <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The two serial units never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mrsp.busy && drsp.busy))
    else $error("multiplier and divider busy together");

  // A start is never issued to a running unit
  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_go_r |-> !mrsp.busy)
    else $error("multiplier restarted while busy");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_go_r |-> (!drsp.busy && !mrsp.busy))
    else $error("divider started while a unit is busy");

  // An accepted item closes the input until it is finished
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after an item was taken");

endmodule

`default_nettype wire
